FILE: src/fac_pkg.sv
// Package for the frustum box culler: widths, plane word layout and result codes.
// Used by fac_csr, fac_plane and frustum_aabb_cull; depends on nothing else.
package fac_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int PLANE_COUNT     = 6;
   localparam int PLANE_WIDTH     = 64;
   localparam int FIELD_WIDTH     = 16;
   localparam int NORMAL_FRAC     = 14;
   localparam int AXIS_COUNT      = 3;
   localparam int OFFSET_FIELD    = 3;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int PROD_WIDTH      = FIELD_WIDTH + COORD_WIDTH;
   localparam int OFFSET_WIDTH    = FIELD_WIDTH + NORMAL_FRAC;
   localparam int SUM_WIDTH       = ((PROD_WIDTH > OFFSET_WIDTH) ? PROD_WIDTH : OFFSET_WIDTH) + 2;

   typedef logic [AXIS_COUNT-1:0][COORD_WIDTH-1:0] coord_vec_type;
   typedef logic [PLANE_COUNT-1:0][PLANE_WIDTH-1:0] plane_array_type;

   typedef struct packed {
      logic outside;
      logic straddle;
   } plane_flags_type;

   typedef enum logic [1:0] {
      CLASS_INSIDE    = 2'd0,
      CLASS_INTERSECT = 2'd1,
      CLASS_OUTSIDE   = 2'd2
   } cull_class_type;

endpackage

FILE: src/frustum_aabb_cull.sv
// Frustum box culler top level: box register, six plane units, result register.
// A box word passes through the box register, the plane product registers and then the result register.
// Throughput is one box word per cycle; all three stages stall together when the
// result register is full and not being taken.
// Synchronous active-high reset clears the valid bits and all six planes to zero.
// Depends on fac_pkg, fac_csr and fac_plane.
module frustum_aabb_cull (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [fac_pkg::COORD_WIDTH-1:0] req_min_x,
   input  logic signed [fac_pkg::COORD_WIDTH-1:0] req_min_y,
   input  logic signed [fac_pkg::COORD_WIDTH-1:0] req_min_z,
   input  logic signed [fac_pkg::COORD_WIDTH-1:0] req_max_x,
   input  logic signed [fac_pkg::COORD_WIDTH-1:0] req_max_y,
   input  logic signed [fac_pkg::COORD_WIDTH-1:0] req_max_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_cull_class,
   output logic                                  rsp_visible,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fac_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [fac_pkg::PLANE_WIDTH-1:0]       csr_data
);

   logic                     advance;
   logic                     box_valid_ff;
   logic                     box_valid_in;
   logic                     prod_valid_ff;
   logic                     prod_valid_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   fac_pkg::coord_vec_type   box_lo_ff;
   fac_pkg::coord_vec_type   box_hi_ff;
   fac_pkg::cull_class_type  rsp_class_ff;
   fac_pkg::cull_class_type  rsp_class_in;
   fac_pkg::plane_array_type planes;
   fac_pkg::plane_flags_type flags [fac_pkg::PLANE_COUNT];
   logic                     any_outside;
   logic                     any_straddle;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   fac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .planes    (planes)
   );

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         box_lo_ff <= {req_min_z, req_min_y, req_min_x};
         box_hi_ff <= {req_max_z, req_max_y, req_max_x};
      end
   end

   for (genvar p = 0; p < fac_pkg::PLANE_COUNT; p++) begin : g_plane
      fac_plane u_plane (
         .clock   (clock),
         .advance (advance),
         .plane   (planes[p]),
         .box_lo  (box_lo_ff),
         .box_hi  (box_hi_ff),
         .flags   (flags[p])
      );
   end

   always_comb begin
      any_outside  = 1'b0;
      any_straddle = 1'b0;
      for (int p = 0; p < fac_pkg::PLANE_COUNT; p++) begin
         any_outside  = any_outside  | flags[p].outside;
         any_straddle = any_straddle | flags[p].straddle;
      end
   end

   always_comb begin
      if (any_outside) begin
         rsp_class_in = fac_pkg::CLASS_OUTSIDE;
      end else if (any_straddle) begin
         rsp_class_in = fac_pkg::CLASS_INTERSECT;
      end else begin
         rsp_class_in = fac_pkg::CLASS_INSIDE;
      end
   end

   assign box_valid_in  = advance ? req_valid     : box_valid_ff;
   assign prod_valid_in = advance ? box_valid_ff  : prod_valid_ff;
   assign rsp_valid_in  = advance ? prod_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         box_valid_ff  <= box_valid_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_class_ff <= rsp_class_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cull_class = rsp_class_ff;
   assign rsp_visible    = (rsp_class_ff != fac_pkg::CLASS_OUTSIDE);

`ifndef SYNTHESIS
   a_accept_loads_box: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> box_valid_ff)
      else $error("Accepted box word did not reach the box register.");

   a_box_moves_on: assert property (@(posedge clock) disable iff (reset)
      box_valid_ff && advance |=> prod_valid_ff)
      else $error("Box stage word was lost before the product stage.");

   a_prod_moves_on: assert property (@(posedge clock) disable iff (reset)
      prod_valid_ff && advance |=> rsp_valid_ff)
      else $error("Product stage word was lost before the result register.");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(box_valid_ff) && $stable(prod_valid_ff))
      else $error("Pipeline moved while the result register was stalled.");

   a_visible_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_visible == (rsp_cull_class != fac_pkg::CLASS_OUTSIDE)))
      else $error("Visible flag disagrees with the class code.");
`endif

endmodule

FILE: src/fac_csr.sv
// Plane register file of the frustum box culler: six 64-bit plane words.
// Depends on fac_pkg.
module fac_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [fac_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [fac_pkg::PLANE_WIDTH-1:0]        csr_data,
   output fac_pkg::plane_array_type               planes
);

   fac_pkg::plane_array_type planes_ff;
   fac_pkg::plane_array_type planes_in;

   always_comb begin
      planes_in = planes_ff;
      if (csr_valid && (csr_index < fac_pkg::CSR_INDEX_WIDTH'(fac_pkg::PLANE_COUNT))) begin
         planes_in[csr_index] = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff <= '0;
      end else begin
         planes_ff <= planes_in;
      end
   end

   assign planes = planes_ff;

endmodule

FILE: src/fac_plane.sv
// One plane test: corner selection and products in a register, then the sums
// and their compares with zero. Depends on fac_pkg.
module fac_plane (
   input  logic                              clock,
   input  logic                              advance,
   input  logic [fac_pkg::PLANE_WIDTH-1:0]   plane,
   input  fac_pkg::coord_vec_type            box_lo,
   input  fac_pkg::coord_vec_type            box_hi,
   output fac_pkg::plane_flags_type          flags
);

   logic signed [fac_pkg::PROD_WIDTH-1:0] pos_prod_in [fac_pkg::AXIS_COUNT];
   logic signed [fac_pkg::PROD_WIDTH-1:0] neg_prod_in [fac_pkg::AXIS_COUNT];
   logic signed [fac_pkg::PROD_WIDTH-1:0] pos_prod_ff [fac_pkg::AXIS_COUNT];
   logic signed [fac_pkg::PROD_WIDTH-1:0] neg_prod_ff [fac_pkg::AXIS_COUNT];
   logic signed [fac_pkg::SUM_WIDTH-1:0]  offset_in;
   logic signed [fac_pkg::SUM_WIDTH-1:0]  offset_ff;
   logic signed [fac_pkg::SUM_WIDTH-1:0]  pos_sum;
   logic signed [fac_pkg::SUM_WIDTH-1:0]  neg_sum;
   logic signed [fac_pkg::FIELD_WIDTH-1:0] offset_field;
   logic signed [fac_pkg::SUM_WIDTH-1:0]  offset_ext;

   always_comb begin
      logic signed [fac_pkg::FIELD_WIDTH-1:0] normal;
      logic signed [fac_pkg::COORD_WIDTH-1:0] lo;
      logic signed [fac_pkg::COORD_WIDTH-1:0] hi;
      logic signed [fac_pkg::COORD_WIDTH-1:0] big;
      logic signed [fac_pkg::COORD_WIDTH-1:0] tiny;
      logic signed [fac_pkg::PROD_WIDTH-1:0]  normal_ext;
      logic signed [fac_pkg::PROD_WIDTH-1:0]  pos_coord;
      logic signed [fac_pkg::PROD_WIDTH-1:0]  neg_coord;
      for (int a = 0; a < fac_pkg::AXIS_COUNT; a++) begin
         normal     = $signed(plane[a*fac_pkg::FIELD_WIDTH +: fac_pkg::FIELD_WIDTH]);
         lo         = $signed(box_lo[a]);
         hi         = $signed(box_hi[a]);
         big        = (lo > hi) ? lo : hi;
         tiny       = (lo > hi) ? hi : lo;
         normal_ext = fac_pkg::PROD_WIDTH'(normal);
         // A negative normal turns the larger coordinate into the smaller product.
         pos_coord  = fac_pkg::PROD_WIDTH'(normal[fac_pkg::FIELD_WIDTH-1] ? tiny : big);
         neg_coord  = fac_pkg::PROD_WIDTH'(normal[fac_pkg::FIELD_WIDTH-1] ? big : tiny);
         pos_prod_in[a] = normal_ext * pos_coord;
         neg_prod_in[a] = normal_ext * neg_coord;
      end
   end

   assign offset_field = $signed(plane[fac_pkg::OFFSET_FIELD*fac_pkg::FIELD_WIDTH +:
                                       fac_pkg::FIELD_WIDTH]);
   assign offset_ext   = fac_pkg::SUM_WIDTH'(offset_field);
   assign offset_in    = $signed({offset_ext[fac_pkg::SUM_WIDTH-fac_pkg::NORMAL_FRAC-1:0],
                                  {fac_pkg::NORMAL_FRAC{1'b0}}});

   always_ff @(posedge clock) begin
      if (advance) begin
         pos_prod_ff <= pos_prod_in;
         neg_prod_ff <= neg_prod_in;
         offset_ff   <= offset_in;
      end
   end

   assign pos_sum = offset_ff
                  + fac_pkg::SUM_WIDTH'(pos_prod_ff[0])
                  + fac_pkg::SUM_WIDTH'(pos_prod_ff[1])
                  + fac_pkg::SUM_WIDTH'(pos_prod_ff[2]);
   assign neg_sum = offset_ff
                  + fac_pkg::SUM_WIDTH'(neg_prod_ff[0])
                  + fac_pkg::SUM_WIDTH'(neg_prod_ff[1])
                  + fac_pkg::SUM_WIDTH'(neg_prod_ff[2]);

   assign flags.outside  = (neg_sum > 0);
   assign flags.straddle = (pos_sum > 0);

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for frustum_aabb_cull: box words are driven with random idling,
// plane-register words are written between them, and every result word is checked against a predictor.
// Depends on fac_pkg and the frustum_aabb_cull RTL.
module testbench;

   localparam int RESULT_LATENCY  = 3;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int UNIT            = 1 << fac_pkg::NORMAL_FRAC;
   localparam int HALF_CUBE       = 2560;

   typedef enum logic [fac_pkg::CSR_INDEX_WIDTH-1:0] {
      REG_LEFT, REG_RIGHT, REG_BOTTOM, REG_TOP, REG_NEAR, REG_FAR,
      REG_SPARE_LOW, REG_SPARE_HIGH
   } plane_reg_type;

   typedef struct {
      fac_pkg::cull_class_type cull_class;
      logic                    visible;
   } cull_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [fac_pkg::COORD_WIDTH-1:0] req_min_x = '0;
   logic signed [fac_pkg::COORD_WIDTH-1:0] req_min_y = '0;
   logic signed [fac_pkg::COORD_WIDTH-1:0] req_min_z = '0;
   logic signed [fac_pkg::COORD_WIDTH-1:0] req_max_x = '0;
   logic signed [fac_pkg::COORD_WIDTH-1:0] req_max_y = '0;
   logic signed [fac_pkg::COORD_WIDTH-1:0] req_max_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_cull_class;
   logic rsp_visible;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [fac_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [fac_pkg::PLANE_WIDTH-1:0] csr_data = '0;

   fac_pkg::plane_array_type plane_regs = '0;
   cull_word_type   expected_words[$];
   int error_count = 0;
   int stall_cycles = 0;
   int hold_off_request = 0;
   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;

   frustum_aabb_cull dut (.*);

   always #5 clock = ~clock;

   function automatic fac_pkg::cull_class_type classify_box(
         input fac_pkg::coord_vec_type lo, input fac_pkg::coord_vec_type hi);
      longint most_pos, most_neg, normal, prod_lo, prod_hi;
      bit outside, straddle;
      int p, a;
      outside = 1'b0;
      straddle = 1'b0;
      for (p = 0; p < fac_pkg::PLANE_COUNT; p++) begin
         most_pos = longint'($signed(plane_regs[p][fac_pkg::OFFSET_FIELD*fac_pkg::FIELD_WIDTH
                                                   +: fac_pkg::FIELD_WIDTH]))
                    <<< fac_pkg::NORMAL_FRAC;
         most_neg = most_pos;
         for (a = 0; a < fac_pkg::AXIS_COUNT; a++) begin
            normal = longint'($signed(plane_regs[p][a*fac_pkg::FIELD_WIDTH
                                                    +: fac_pkg::FIELD_WIDTH]));
            prod_lo = normal * longint'($signed(lo[a]));
            prod_hi = normal * longint'($signed(hi[a]));
            most_pos += (prod_lo > prod_hi) ? prod_lo : prod_hi;
            most_neg += (prod_lo < prod_hi) ? prod_lo : prod_hi;
         end
         if (most_neg > 0) outside = 1'b1;
         if (most_pos > 0) straddle = 1'b1;
      end
      if (outside) return fac_pkg::CLASS_OUTSIDE;
      if (straddle) return fac_pkg::CLASS_INTERSECT;
      return fac_pkg::CLASS_INSIDE;
   endfunction

   function automatic logic [fac_pkg::PLANE_WIDTH-1:0] pack_plane(input int nx, ny, nz,
                                                                  offset);
      return {offset[fac_pkg::FIELD_WIDTH-1:0], nz[fac_pkg::FIELD_WIDTH-1:0],
              ny[fac_pkg::FIELD_WIDTH-1:0], nx[fac_pkg::FIELD_WIDTH-1:0]};
   endfunction

   function automatic int signed_spread(input int reach);
      return int'($urandom_range(0, 2 * reach)) - reach;
   endfunction

   function automatic logic [fac_pkg::PLANE_WIDTH-1:0] random_plane();
      if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
      return pack_plane(signed_spread(UNIT), signed_spread(UNIT), signed_spread(UNIT),
                        signed_spread(6000));
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      cull_word_type word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("result word with none expected, class", rsp_cull_class, -1);
         end else begin
            word = expected_words.pop_front();
            if (rsp_cull_class !== word.cull_class)
               report_mismatch("cull_class", rsp_cull_class, word.cull_class);
            if (rsp_visible !== word.visible)
               report_mismatch("visible", rsp_visible, word.visible);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always begin
      @(posedge clock);
      if (hold_off_request > 0) begin
         rsp_ready <= 1'b0;
         repeat (hold_off_request) @(posedge clock);
         hold_off_request = 0;
      end else if (receiver_idles && !reset && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      rsp_ready <= 1'b1;
   end

   // Valid is left high after acceptance so that back-to-back words need no gap.
   task automatic send_box(input int x0, y0, z0, x1, y1, z1);
      fac_pkg::coord_vec_type lo, hi;
      cull_word_type word;
      lo[0] = x0[fac_pkg::COORD_WIDTH-1:0];
      lo[1] = y0[fac_pkg::COORD_WIDTH-1:0];
      lo[2] = z0[fac_pkg::COORD_WIDTH-1:0];
      hi[0] = x1[fac_pkg::COORD_WIDTH-1:0];
      hi[1] = y1[fac_pkg::COORD_WIDTH-1:0];
      hi[2] = z1[fac_pkg::COORD_WIDTH-1:0];
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_min_x <= lo[0];
      req_min_y <= lo[1];
      req_min_z <= lo[2];
      req_max_x <= hi[0];
      req_max_y <= hi[1];
      req_max_z <= hi[2];
      do @(posedge clock); while (!req_ready);
      word.cull_class = classify_box(lo, hi);
      word.visible = (word.cull_class != fac_pkg::CLASS_OUTSIDE);
      expected_words.push_back(word);
   endtask

   task automatic send_random_box(input int reach);
      int lo[3], hi[3], centre, half, a;
      if ($urandom_range(0, 4) == 0) begin
         send_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
         for (a = 0; a < fac_pkg::AXIS_COUNT; a++) begin
            centre = signed_spread(reach);
            half = $urandom_range(0, reach / 2);
            lo[a] = centre - half;
            hi[a] = centre + half;
         end
         if ($urandom_range(0, 7) == 0)
            send_box(hi[0], hi[1], hi[2], lo[0], lo[1], lo[2]);
         else
            send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
      end
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_register(input plane_reg_type index,
                                 input logic [fac_pkg::PLANE_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (index < fac_pkg::PLANE_COUNT) plane_regs[index] = value;
   endtask

   task automatic config_planes(input fac_pkg::plane_array_type values);
      int p;
      for (p = 0; p < fac_pkg::PLANE_COUNT; p++)
         write_register(plane_reg_type'(p), values[p]);
      csr_valid <= 1'b0;
   endtask

   function automatic fac_pkg::plane_array_type cube_planes();
      fac_pkg::plane_array_type planes;
      planes[REG_LEFT]   = pack_plane(-UNIT, 0, 0, -HALF_CUBE);
      planes[REG_RIGHT]  = pack_plane(UNIT, 0, 0, -HALF_CUBE);
      planes[REG_BOTTOM] = pack_plane(0, -UNIT, 0, -HALF_CUBE);
      planes[REG_TOP]    = pack_plane(0, UNIT, 0, -HALF_CUBE);
      planes[REG_NEAR]   = pack_plane(0, 0, -UNIT, -HALF_CUBE);
      planes[REG_FAR]    = pack_plane(0, 0, UNIT, -HALF_CUBE);
      return planes;
   endfunction

   function automatic fac_pkg::plane_array_type view_planes();
      fac_pkg::plane_array_type planes;
      planes[REG_LEFT]   = pack_plane(-11585, 0, -11585, 0);
      planes[REG_RIGHT]  = pack_plane(11585, 0, -11585, 0);
      planes[REG_BOTTOM] = pack_plane(0, -11585, -11585, 0);
      planes[REG_TOP]    = pack_plane(0, 11585, -11585, 0);
      planes[REG_NEAR]   = pack_plane(0, 0, -UNIT, 256);
      planes[REG_FAR]    = pack_plane(0, 0, UNIT, -25600);
      return planes;
   endfunction

   function automatic fac_pkg::plane_array_type random_planes();
      fac_pkg::plane_array_type planes;
      int p;
      for (p = 0; p < fac_pkg::PLANE_COUNT; p++) planes[p] = random_plane();
      return planes;
   endfunction

   // With every plane cleared after reset, every box must come back inside.
   task automatic test_reset_planes();
      send_box(-32768, -32768, -32768, 32767, 32767, 32767);
      send_box(0, 0, 0, 0, 0, 0);
      send_box(32767, -32768, 32767, -32768, 32767, -32768);
      drain_pipeline();
   endtask

   task automatic test_directed_cube();
      config_planes(cube_planes());
      send_box(-256, -256, -256, 256, 256, 256);
      send_box(2000, 0, 0, 3000, 256, 256);
      send_box(-5000, 0, 0, -3000, 0, 0);
      send_box(3000, 0, 0, 5000, 0, 0);
      send_box(0, -5000, 0, 0, -3000, 0);
      send_box(0, 3000, 0, 0, 5000, 0);
      send_box(0, 0, -5000, 0, 0, -3000);
      send_box(0, 0, 3000, 0, 0, 5000);
      send_box(256, 256, 256, -256, -256, -256);
      send_box(3000, 256, 256, 2000, 0, 0);
      // Faces of the box lie exactly on the planes, so the largest distance to each plane is zero.
      send_box(-HALF_CUBE, -HALF_CUBE, -HALF_CUBE, HALF_CUBE, HALF_CUBE, HALF_CUBE);
      send_box(-HALF_CUBE - 1, -HALF_CUBE, -HALF_CUBE, HALF_CUBE, HALF_CUBE, HALF_CUBE);
      send_box(HALF_CUBE, 0, 0, 3000, 0, 0);
      send_box(HALF_CUBE + 1, 0, 0, 3000, 0, 0);
      send_box(-32768, -32768, -32768, 32767, 32767, 32767);
      send_box(-32768, -32768, -32768, -32768, -32768, -32768);
      send_box(32767, 32767, 32767, 32767, 32767, 32767);
      send_box(0, 0, 0, 0, 0, 0);
      drain_pipeline();
   endtask

   // Writes to the two indexes beyond the plane file must leave the planes untouched.
   task automatic test_register_index();
      write_register(REG_SPARE_LOW, {$urandom, $urandom});
      write_register(REG_SPARE_HIGH, {fac_pkg::PLANE_WIDTH{1'b1}});
      csr_valid <= 1'b0;
      send_box(-256, -256, -256, 256, 256, 256);
      send_box(2000, 0, 0, 3000, 256, 256);
      send_box(-5000, 0, 0, -3000, 0, 0);
      drain_pipeline();
   endtask

   task automatic test_random_view();
      config_planes(view_planes());
      repeat (200) send_random_box(12000);
      drain_pipeline();
   endtask

   task automatic test_random_planes();
      int round;
      for (round = 0; round < 4; round++) begin
         config_planes(random_planes());
         repeat (40) send_random_box(8000);
         drain_pipeline();
      end
   endtask

   task automatic test_extreme_planes();
      fac_pkg::plane_array_type planes;
      int p;
      for (p = 0; p < fac_pkg::PLANE_COUNT; p++) planes[p] = {4{16'h7fff}};
      config_planes(planes);
      repeat (30) send_random_box(16000);
      drain_pipeline();
      for (p = 0; p < fac_pkg::PLANE_COUNT; p++) planes[p] = {4{16'h8000}};
      config_planes(planes);
      repeat (30) send_random_box(16000);
      drain_pipeline();
      for (p = 0; p < fac_pkg::PLANE_COUNT; p++)
         planes[p] = (p % 2 == 0) ? {fac_pkg::PLANE_WIDTH{1'b1}} : {2{32'h80007fff}};
      config_planes(planes);
      repeat (30) send_random_box(16000);
      drain_pipeline();
      config_planes('0);
      repeat (10) send_random_box(16000);
      drain_pipeline();
   endtask

   // The receiver stops for a long stretch so that the pipeline fills and stalls its input.
   task automatic test_backpressure();
      config_planes(view_planes());
      hold_off_request = HOLD_OFF_CYCLES;
      repeat (60) send_random_box(12000);
      drain_pipeline();
   endtask

   task automatic test_steady_stream();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      config_planes(random_planes());
      repeat (120) send_random_box(8000);
      drain_pipeline();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_planes();
      test_directed_cube();
      test_register_index();
      test_random_view();
      test_random_planes();
      test_extreme_planes();
      test_backpressure();
      test_steady_stream();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
